### rtl/dlps_pkg.sv
// Shared types, constants and the half-sine gain table of the pitch shifter.
`timescale 1ns / 1ps
package dlps_pkg;

  localparam int WINDOW_DEF    = 2048;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SAMPLE_W      = 16;
  localparam int RATE_W        = 19;
  localparam int RATE_FRAC     = 16;
  localparam int MODE_W        = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 19;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT = 2'd1;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHIFT = 2'd2;

  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_SHIFT = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [SAMPLE_W-1:0] sample;
  } q_entry_t;

  // Gain for crossfade position k (0..63): a half sine period in Q0.15.
  function automatic logic [15:0] qsine_gain(input logic [5:0] k);
    logic [5:0]  idx;
    logic [15:0] g;
    idx = (k <= 6'd32) ? k : 6'(7'd64 - {1'b0, k});
    unique case (idx)
      6'd0:  g = 16'd0;
      6'd1:  g = 16'd1608;
      6'd2:  g = 16'd3212;
      6'd3:  g = 16'd4808;
      6'd4:  g = 16'd6393;
      6'd5:  g = 16'd7962;
      6'd6:  g = 16'd9512;
      6'd7:  g = 16'd11039;
      6'd8:  g = 16'd12539;
      6'd9:  g = 16'd14010;
      6'd10: g = 16'd15446;
      6'd11: g = 16'd16846;
      6'd12: g = 16'd18205;
      6'd13: g = 16'd19519;
      6'd14: g = 16'd20787;
      6'd15: g = 16'd22005;
      6'd16: g = 16'd23170;
      6'd17: g = 16'd24279;
      6'd18: g = 16'd25329;
      6'd19: g = 16'd26319;
      6'd20: g = 16'd27245;
      6'd21: g = 16'd28105;
      6'd22: g = 16'd28898;
      6'd23: g = 16'd29621;
      6'd24: g = 16'd30273;
      6'd25: g = 16'd30852;
      6'd26: g = 16'd31356;
      6'd27: g = 16'd31785;
      6'd28: g = 16'd32137;
      6'd29: g = 16'd32412;
      6'd30: g = 16'd32609;
      6'd31: g = 16'd32728;
      6'd32: g = 16'd32767;
      default: g = 16'd0;
    endcase
    return g;
  endfunction

endpackage

### rtl/dlps_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module dlps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/dlps_front.sv
// Front end: accepts samples, tags each with its operation and queues it.
`timescale 1ns / 1ps
module dlps_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dlps_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic [dlps_pkg::MODE_W-1:0]    mode_i,
  input  logic                           busy_i,
  output logic                           q_valid_o,
  input  logic                           q_ready_i,
  output dlps_pkg::q_entry_t             q_entry_o
);
  import dlps_pkg::*;

  q_entry_t   fifo_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  kind_e      kind;

  // Unused mode code behaves as disabled.
  always_comb begin
    if (mode_i == MODE_WRITE) begin
      kind = KIND_WRITE;
    end else if (mode_i == MODE_SHIFT) begin
      kind = KIND_SHIFT;
    end else begin
      kind = KIND_PASS;
    end
  end

  assign in_ready_o = (cnt_q != 2'd2) && !busy_i;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_entry_o  = fifo_q[rptr_q];

  assign wptr_d = push ? ~wptr_q : wptr_q;
  assign rptr_d = pop ? ~rptr_q : rptr_q;
  assign cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= '{kind: kind, sample: sample_in_i};
    end
  end

endmodule

### rtl/dlps_back.sv
// Back end: delay line, read delay, two interpolated taps and crossfade sum.
`timescale 1ns / 1ps
module dlps_back #(
  parameter int WINDOW    = dlps_pkg::WINDOW_DEF,
  parameter int FRAC_BITS = dlps_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  output logic                                  q_ready_o,
  input  dlps_pkg::q_entry_t                    q_entry_i,
  input  logic signed [dlps_pkg::RATE_W-1:0]    drift_rate_i,
  output logic                                  busy_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [dlps_pkg::SAMPLE_W-1:0]  sample_out_o
);
  import dlps_pkg::*;

  localparam int LINE_LEN = 2 * WINDOW;
  localparam int AW       = $clog2(LINE_LEN);
  localparam int DW       = $clog2(WINDOW) + FRAC_BITS;
  localparam int PW       = DW + 1;
  localparam int UP       = (FRAC_BITS >= RATE_FRAC) ? FRAC_BITS - RATE_FRAC : 0;
  localparam int DN       = (FRAC_BITS < RATE_FRAC) ? RATE_FRAC - FRAC_BITS : 0;
  localparam int RXW      = DW + RATE_W + UP;
  localparam int LW       = FRAC_BITS + 18;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_MUL   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d, wp_q, wp_d;
  logic [DW-1:0] delay_q, delay_d;
  logic [2:0]    rd_q, rd_d;
  logic [1:0]    step_q, step_d;
  logic          ov_q, ov_d;
  logic signed [SAMPLE_W-1:0] so_q, so_d;
  logic signed [SAMPLE_W-1:0] smp_q [4];
  logic signed [LW-1:0]       lerp_q;
  logic signed [35:0]         acc_q;

  logic          out_free, pop, out_load;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  logic signed [RXW-1:0] rate_x;
  logic [DW-1:0] delay_b;
  logic [PW-1:0] pos_a, pos_b;
  logic [AW-1:0] addr [4];
  logic [FRAC_BITS-1:0] fa, fb, fsel;
  logic [15:0]   ga, gb, gsel;
  logic signed [16:0] diff;
  logic signed [LW-1:0] lerp_d;
  logic signed [17:0] tap;
  logic signed [34:0] prod;
  logic signed [35:0] rsum;
  logic signed [20:0] yfull;
  logic signed [SAMPLE_W-1:0] ysat;

  dlps_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_LEN)) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Rate rescaled to the delay's fraction bits, floored when narrowing.
  assign rate_x = (RXW'(drift_rate_i) <<< UP) >>> DN;

  // Second tap is half a window away: flip the delay's top bit.
  assign delay_b = {~delay_q[DW-1], delay_q[DW-2:0]};
  assign pos_a   = {wp_q, {FRAC_BITS{1'b0}}} - {1'b0, delay_q};
  assign pos_b   = {wp_q, {FRAC_BITS{1'b0}}} - {1'b0, delay_b};
  assign addr[0] = pos_a[PW-1:FRAC_BITS];
  assign addr[1] = pos_a[PW-1:FRAC_BITS] + 1'b1;
  assign addr[2] = pos_b[PW-1:FRAC_BITS];
  assign addr[3] = pos_b[PW-1:FRAC_BITS] + 1'b1;
  assign fa      = pos_a[FRAC_BITS-1:0];
  assign fb      = pos_b[FRAC_BITS-1:0];
  assign ga      = qsine_gain(delay_q[DW-1 -: 6]);
  assign gb      = qsine_gain(delay_b[DW-1 -: 6]);

  // Shared interpolation multiplier: tap = s0 + floor((s1 - s0) * f / 2^F).
  assign diff   = (step_q == 2'd0) ? (17'(smp_q[1]) - 17'(smp_q[0]))
                                   : (17'(smp_q[3]) - 17'(smp_q[2]));
  assign fsel   = (step_q == 2'd0) ? fa : fb;
  assign lerp_d = LW'(diff * $signed({1'b0, fsel}));
  assign tap    = 18'((step_q == 2'd1) ? smp_q[0] : smp_q[2]) + 18'(lerp_q >>> FRAC_BITS);
  assign gsel   = (step_q == 2'd1) ? ga : gb;
  assign prod   = 35'(tap * $signed({1'b0, gsel}));

  assign rsum  = acc_q + 36'sd16384;
  assign yfull = 21'(rsum >>> 15);
  always_comb begin
    if (yfull > 21'sd32767) begin
      ysat = 16'sh7fff;
    end else if (yfull < -21'sd32768) begin
      ysat = -16'sh8000;
    end else begin
      ysat = yfull[15:0];
    end
  end

  assign out_free    = !ov_q || out_ready_i;
  assign q_ready_o   = (state_q == S_IDLE) &&
                       ((q_entry_i.kind == KIND_SHIFT) || out_free);
  assign pop         = q_valid_i && q_ready_o;
  assign busy_o      = (state_q == S_CLEAR);
  assign out_valid_o = ov_q;
  assign sample_out_o = so_q;
  assign ram_raddr   = addr[rd_q[1:0]];

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    wp_d      = wp_q;
    delay_d   = delay_q;
    rd_d      = rd_q;
    step_d    = step_q;
    out_load  = 1'b0;
    so_d      = so_q;
    ram_we    = 1'b0;
    ram_waddr = wp_q;
    ram_wdata = q_entry_i.sample;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(LINE_LEN - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          if (q_entry_i.kind != KIND_PASS) begin
            ram_we = 1'b1;
            wp_d   = wp_q + 1'b1;
          end
          if (q_entry_i.kind == KIND_SHIFT) begin
            delay_d = delay_q + rate_x[DW-1:0];
            rd_d    = 3'd0;
            state_d = S_READ;
          end else begin
            out_load = 1'b1;
            so_d     = q_entry_i.sample;
          end
        end
      end
      S_READ: begin
        rd_d = rd_q + 3'd1;
        if (rd_q == 3'd4) begin
          step_d  = 2'd0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        step_d = step_q + 2'd1;
        if (step_q == 2'd2) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          so_d     = ysat;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ov_d = out_load || (ov_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      wp_q    <= '0;
      delay_q <= '0;
      rd_q    <= '0;
      step_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wp_q    <= wp_d;
      delay_q <= delay_d;
      rd_q    <= rd_d;
      step_q  <= step_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    so_q <= so_d;
    if (state_q == S_READ && rd_q != 3'd0) begin
      smp_q[rd_q[1:0] - 2'd1] <= ram_rdata;
    end
    if (state_q == S_MUL) begin
      lerp_q <= lerp_d;
      if (step_q == 2'd1) begin
        acc_q <= 36'(prod);
      end else if (step_q == 2'd2) begin
        acc_q <= acc_q + 36'(prod);
      end
    end
  end

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("back state not one-hot");
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !q_ready_o) else $error("pop during clear");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free) else $error("pending result overwritten");
  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (rd_q <= 3'd4)) else $error("read counter overrun");
  a_mul_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (step_q <= 2'd2)) else $error("step counter overrun");
`endif

endmodule

### rtl/delay_line_pitch_shifter_unit.sv
// Top level of the two-tap crossfading delay-line pitch shifter.
//
//   Channel  Direction  Handshake              Payload
//   in       into       in_valid_i/in_ready_o  sample_in_i  (signed Q1.15)
//   out      out of     out_valid_o/out_ready_i sample_out_o (signed Q1.15)
//   cfg      into       cfg_we_i (no wait)     cfg_idx_i, cfg_data_i
//
// Disabled and write-only requests are finished by the back end straight from idle;
// a pitch-shift request writes the line and moves the read delay, then reads the
// four tap samples on the single RAM read port, then works on the shared
// multipliers, and last rounds and saturates. After reset the line's 2*WINDOW
// entries (4096 by default) are cleared with in_ready_o low; configuration
// writes are taken then. A two-entry queue lets requests keep arriving while the
// back end works or while the output register waits on out_ready_i.
`timescale 1ns / 1ps
module delay_line_pitch_shifter_unit #(
  // WINDOW is a power of two; the line holds twice as many samples.
  parameter int WINDOW    = dlps_pkg::WINDOW_DEF,
  parameter int FRAC_BITS = dlps_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [dlps_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [dlps_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [dlps_pkg::SAMPLE_W-1:0]   sample_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [dlps_pkg::SAMPLE_W-1:0]   sample_out_o
);
  import dlps_pkg::*;

  // Configuration registers; writes to other indexes are dropped.
  logic [MODE_W-1:0]        mode_q;
  logic signed [RATE_W-1:0] drift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      drift_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MODE) begin
        mode_q <= cfg_data_i[MODE_W-1:0];
      end else if (cfg_idx_i == REG_DRIFT) begin
        drift_q <= $signed(cfg_data_i[RATE_W-1:0]);
      end
    end
  end

  logic     q_valid, q_ready, busy;
  q_entry_t q_entry;

  // The front end tags each request with the mode in force when it arrives.
  dlps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .mode_i      (mode_q),
    .busy_i      (busy),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_entry_o   (q_entry)
  );

  // The back end owns the line memory, the write position and the read delay.
  dlps_back #(.WINDOW(WINDOW), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_entry_i    (q_entry),
    .drift_rate_i (drift_q),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

endmodule
